// File: sv/accel_stillness_detector_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ACCEL_STILLNESS_DETECTOR_MACROS_SVH
`define ACCEL_STILLNESS_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/asd_pkg.sv
package asd_pkg;

  localparam int WINDOW_LENGTH = 20;
  localparam int SAMPLE_BITS   = 16;

  localparam int FLIP_W = 16;
  localparam int MOT_W  = 16;
  localparam int VAR_W  = 32;

  localparam int ADDR_W = $clog2(WINDOW_LENGTH);
  // sweep counter runs up to WINDOW_LENGTH + 1
  localparam int CNT_W  = $clog2(WINDOW_LENGTH + 2);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LENGTH) + 1;
  localparam int U_W   = SUM_W - 1;

  // floor(u / WINDOW_LENGTH) = (u * RECIP) >> RECIP_SHIFT for u < WINDOW_LENGTH << SAMPLE_BITS
  localparam int RECIP_SHIFT = SAMPLE_BITS + 2 * $clog2(WINDOW_LENGTH);
  localparam int RECIP_W     = RECIP_SHIFT - $clog2(WINDOW_LENGTH) + 1;
  localparam int PROD_W      = U_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) / WINDOW_LENGTH) + 64'd1);
  localparam logic [SUM_W-1:0] MEAN_OFFSET =
    SUM_W'(64'(WINDOW_LENGTH) << (SAMPLE_BITS - 1));

  localparam int DEV_W = SAMPLE_BITS + 1;
  localparam int SQ_W  = 2 * SAMPLE_BITS + 1;
  localparam int CMP_W = ((2 * SAMPLE_BITS > VAR_W) ? 2 * SAMPLE_BITS : VAR_W)
                         + $clog2(WINDOW_LENGTH) + 1;

  localparam logic [ADDR_W-1:0] WIN_LAST = ADDR_W'(WINDOW_LENGTH - 1);
  localparam logic [CNT_W-1:0]  CNT_LEN  = CNT_W'(WINDOW_LENGTH);
  localparam logic [CNT_W-1:0]  CNT_TAIL = CNT_W'(WINDOW_LENGTH + 1);
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(3);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } sample_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic done;
    logic quiet;
  } calc_rsp_t;

  typedef enum logic [1:0] {
    CFG_FLIP   = 2'd0,
    CFG_MOTION = 2'd1,
    CFG_VAR    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SUM,
    CS_DIV,
    CS_SPREAD,
    CS_DONE
  } calc_state_e;

endpackage

// File: sv/accel_stillness_detector.sv
// Stillness detector for a three-axis accelerometer. Each input transaction is one
// Q4.12 sample and yields exactly one output transaction (flipped, still). A sample
// taken while quiet, or while moving but not closing the window, has its result in
// the output register in the cycle after acceptance. The sample that fills the last
// window slot starts two sweeps over the single read port of the window memory
// (sum, then squared deviations from the new means) plus the mean division; no input
// is taken before its result is loaded into the output register. A new input is
// taken while a result waits in the output register as long as that register is not
// stalled. Thresholds must be written through the configuration port only while the
// block is idle, which the block itself does not enforce; cfg_ready_o is always high
// and writes to an unused index are ignored.
module accel_stillness_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [asd_pkg::VAR_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              flipped_o,
  output logic                              still_o
);
  import asd_pkg::*;
  `include "accel_stillness_detector_macros.svh"

  logic signed [FLIP_W-1:0] flip_thr_q;
  logic [MOT_W-1:0]         mot_thr_q;
  logic [VAR_W-1:0]         var_thr_q;

  logic [ADDR_W-1:0] fill_q, fill_d;
  logic              quiet_q, quiet_d;
  logic              busy_q, busy_d;
  logic              pend_flip_q;
  logic              out_valid_q, out_flip_q, out_still_q;

  logic      in_accept;
  logic      flip_now;
  logic      dev_any;
  logic      last_slot;
  logic      mem_we;
  logic      calc_start;
  logic      out_load;
  sample_t   sample_in;
  sample_t   rdata;
  sample_t   mean;
  mem_rd_t   rd;
  calc_rsp_t rsp;

  function automatic logic deviates(input logic signed [SAMPLE_BITS-1:0] v,
                                    input logic signed [SAMPLE_BITS-1:0] m,
                                    input logic [MOT_W-1:0] thr);
    logic signed [DEV_W-1:0] d;
    logic [DEV_W-1:0]        a;
    d = DEV_W'(v) - DEV_W'(m);
    a = d[DEV_W-1] ? DEV_W'(-d) : DEV_W'(d);
    return 32'(a) > 32'(thr);
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_thr_q <= 16'sd819;
      mot_thr_q  <= 16'd164;
      var_thr_q  <= 32'd3355;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FLIP:   flip_thr_q <= cfg_data_i[FLIP_W-1:0];
        CFG_MOTION: mot_thr_q  <= cfg_data_i[MOT_W-1:0];
        CFG_VAR:    var_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign sample_in = '{x: accel_x_i, y: accel_y_i, z: accel_z_i};
  assign flip_now  = $signed(32'(accel_z_i)) > $signed(32'(flip_thr_q));
  assign dev_any   = deviates(accel_x_i, mean.x, mot_thr_q)
                  || deviates(accel_y_i, mean.y, mot_thr_q)
                  || deviates(accel_z_i, mean.z, mot_thr_q);
  assign last_slot  = (fill_q >= WIN_LAST);
  assign mem_we     = in_accept && !quiet_q;
  assign calc_start = mem_we && last_slot;
  assign out_load   = (in_accept && !calc_start) || rsp.done;

  always_comb begin
    fill_d  = fill_q;
    quiet_d = quiet_q;
    busy_d  = busy_q;
    if (mem_we) begin
      fill_d = last_slot ? '0 : fill_q + ADDR_W'(1);
    end
    if (in_accept && quiet_q && dev_any) begin
      quiet_d = 1'b0;
    end
    if (calc_start) begin
      busy_d = 1'b1;
    end
    if (rsp.done) begin
      busy_d  = 1'b0;
      quiet_d = rsp.quiet;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      quiet_q     <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      quiet_q <= quiet_d;
      busy_q  <= busy_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_flip_q <= flip_now;
    end
    if (rsp.done) begin
      out_flip_q  <= pend_flip_q;
      out_still_q <= rsp.quiet;
    end else if (in_accept && !calc_start) begin
      out_flip_q  <= flip_now;
      out_still_q <= quiet_q && !dev_any;
    end
  end

  assign out_valid_o = out_valid_q;
  assign flipped_o   = out_flip_q;
  assign still_o     = out_still_q;

  asd_win_mem u_win_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (last_slot ? WIN_LAST : fill_q),
    .wdata_i (sample_in),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  asd_wcalc u_wcalc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (calc_start),
    .var_thr_i (var_thr_q),
    .rdata_i   (rdata),
    .rd_o      (rd),
    .rsp_o     (rsp),
    .mean_o    (mean)
  );

  `ASD_ASSERT_NOW(a_fill_range, 1'b1, fill_q <= WIN_LAST, "fill count beyond window")
  `ASD_ASSERT_NOW(a_write_moving, mem_we, !quiet_q && !busy_q, "window write while quiet or busy")
  `ASD_ASSERT_NOW(a_done_busy, rsp.done, busy_q && !in_accept, "window result without pending transaction")
  `ASD_ASSERT_NEXT(a_start_clears, calc_start, fill_q == '0 && busy_q && !out_valid_q,
                   "window end did not restart the fill or free the output")
  `ASD_ASSERT_NOW(a_no_read_idle, rd.en, busy_q && !mem_we, "memory read outside window sweep")

endmodule

// File: sv/asd_win_mem.sv
module asd_win_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [asd_pkg::ADDR_W-1:0]  waddr_i,
  input  asd_pkg::sample_t            wdata_i,
  input  asd_pkg::mem_rd_t            rd_i,
  output asd_pkg::sample_t            rdata_o
);
  import asd_pkg::*;

  sample_t mem_q [WINDOW_LENGTH];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/asd_wcalc.sv
module asd_wcalc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [asd_pkg::VAR_W-1:0]  var_thr_i,
  input  asd_pkg::sample_t           rdata_i,
  output asd_pkg::mem_rd_t           rd_o,
  output asd_pkg::calc_rsp_t         rsp_o,
  output asd_pkg::sample_t           mean_o
);
  import asd_pkg::*;

  calc_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic             rvld_q;
  logic             sq_vld_q;

  logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic [PROD_W-1:0]       prod_q;
  logic [CMP_W-1:0]        limit_q;
  logic [SQ_W-1:0]         sq_x_q, sq_y_q, sq_z_q;
  logic [CMP_W-1:0]        acc_x_q, acc_y_q, acc_z_q;
  sample_t                 mean_q;

  logic [SUM_W-1:0]              sum_sel;
  logic [SUM_W-1:0]              u_full;
  logic [SAMPLE_BITS-1:0]        quo;
  logic signed [SAMPLE_BITS-1:0] mean_new;

  function automatic logic [SQ_W-1:0] dev_sq(input logic signed [SAMPLE_BITS-1:0] v,
                                             input logic signed [SAMPLE_BITS-1:0] m);
    logic signed [DEV_W-1:0]   d;
    logic signed [2*DEV_W-1:0] p;
    d = DEV_W'(v) - DEV_W'(m);
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE:   if (start_i) state_d = CS_SUM;
      CS_SUM:    if (cnt_q == CNT_LEN) state_d = CS_DIV;
      CS_DIV:    if (cnt_q == DIV_LAST) state_d = CS_SPREAD;
      CS_SPREAD: if (cnt_q == CNT_TAIL) state_d = CS_DONE;
      CS_DONE:   state_d = CS_IDLE;
      default:   state_d = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_o.en   = 1'b0;
    rd_o.addr = cnt_q[ADDR_W-1:0];
    rsp_o     = '0;
    unique case (state_q) inside
      CS_SUM, CS_SPREAD: rd_o.en = (cnt_q < CNT_LEN);
      CS_DONE: begin
        rsp_o.done  = 1'b1;
        rsp_o.quiet = (acc_x_q < limit_q) && (acc_y_q < limit_q) && (acc_z_q < limit_q);
      end
      default: ;
    endcase
  end

  // mean division: offset the sum so it is non-negative, then reciprocal multiply
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sum_sel = sum_x_q;
      2'd1:    sum_sel = sum_y_q;
      default: sum_sel = sum_z_q;
    endcase
    u_full   = sum_sel + MEAN_OFFSET;
    quo      = prod_q[RECIP_SHIFT +: SAMPLE_BITS];
    mean_new = {~quo[SAMPLE_BITS-1], quo[SAMPLE_BITS-2:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CS_IDLE;
      cnt_q    <= '0;
      rvld_q   <= 1'b0;
      sq_vld_q <= 1'b0;
      mean_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
      rvld_q   <= rd_o.en;
      sq_vld_q <= rvld_q && (state_q == CS_SPREAD);
      if (state_q == CS_DIV && cnt_q != '0) begin
        case (cnt_q[1:0])
          2'd1:    mean_q.x <= mean_new;
          2'd2:    mean_q.y <= mean_new;
          default: mean_q.z <= mean_new;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CS_IDLE && start_i) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
    end else if (state_q == CS_SUM && rvld_q) begin
      sum_x_q <= sum_x_q + SUM_W'(rdata_i.x);
      sum_y_q <= sum_y_q + SUM_W'(rdata_i.y);
      sum_z_q <= sum_z_q + SUM_W'(rdata_i.z);
    end

    if (state_q == CS_DIV && cnt_q != DIV_LAST) begin
      prod_q <= PROD_W'(u_full[U_W-1:0]) * PROD_W'(RECIP);
    end
    if (state_q == CS_DIV && cnt_q == '0) begin
      limit_q <= CMP_W'(var_thr_i) * CMP_W'(WINDOW_LENGTH);
    end

    if (state_q == CS_SPREAD && rvld_q) begin
      sq_x_q <= dev_sq(rdata_i.x, mean_q.x);
      sq_y_q <= dev_sq(rdata_i.y, mean_q.y);
      sq_z_q <= dev_sq(rdata_i.z, mean_q.z);
    end

    if (state_q == CS_DIV) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
    end else if (sq_vld_q) begin
      acc_x_q <= acc_x_q + CMP_W'(sq_x_q);
      acc_y_q <= acc_y_q + CMP_W'(sq_y_q);
      acc_z_q <= acc_z_q + CMP_W'(sq_z_q);
    end
  end

  assign mean_o = mean_q;

endmodule

// File: dv/tb_accel_stillness_detector.sv
`timescale 1ns / 100ps

module tb_accel_stillness_detector;
  import asd_pkg::*;

  localparam int STUCK_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 2 * WINDOW_LENGTH + 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 82;

  typedef logic signed [SAMPLE_BITS-1:0] accel_t;

  typedef struct packed {
    logic flipped;
    logic still;
  } verdict_t;

  class stillness_tracker;
    accel_t           flip_level;
    logic [MOT_W-1:0] motion_level;
    logic [VAR_W-1:0] var_level;
    accel_t           win[3][WINDOW_LENGTH];
    accel_t           mean[3];
    int unsigned      fill;
    bit               quiet;
    int               errors;
    verdict_t         pending[$];

    function new();
      flip_level   = 16'sd819;
      motion_level = 16'd164;
      var_level    = 32'd3355;
      fill         = 0;
      quiet        = 1'b0;
      errors       = 0;
      foreach (mean[a]) mean[a] = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [VAR_W-1:0] data);
      case (idx)
        CFG_FLIP:   flip_level = accel_t'(data[FLIP_W-1:0]);
        CFG_MOTION: motion_level = data[MOT_W-1:0];
        CFG_VAR:    var_level = data;
        default: ;
      endcase
    endfunction

    function void note_sample(accel_t x, accel_t y, accel_t z);
      accel_t   s[3];
      verdict_t v;
      longint   sum;
      longint   avg;
      longint   d;
      longint   spread;
      longint   limit;
      bit       calm;
      s[0] = x;
      s[1] = y;
      s[2] = z;
      v.flipped = (z > flip_level);
      if (quiet) begin
        for (int a = 0; a < 3; a++) begin
          d = longint'(s[a]) - longint'(mean[a]);
          if (d < 0) d = -d;
          if (d > longint'(motion_level)) quiet = 1'b0;
        end
      end else begin
        for (int a = 0; a < 3; a++) win[a][fill] = s[a];
        if (fill == WINDOW_LENGTH - 1) begin
          fill  = 0;
          limit = longint'(var_level) * WINDOW_LENGTH;
          calm  = 1'b1;
          for (int a = 0; a < 3; a++) begin
            sum = 0;
            for (int i = 0; i < WINDOW_LENGTH; i++) sum += longint'(win[a][i]);
            // floor division, truncation would round negative sums up
            avg = sum / WINDOW_LENGTH;
            if (sum < 0 && sum % WINDOW_LENGTH != 0) avg = avg - 1;
            mean[a] = accel_t'(avg);
            spread  = 0;
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
              d = longint'(win[a][i]) - avg;
              spread += d * d;
            end
            if (spread >= limit) calm = 1'b0;
          end
          quiet = calm;
        end else begin
          fill++;
        end
      end
      v.still = quiet;
      pending.push_back(v);
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_verdict(logic flipped, logic still);
      verdict_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result flipped=%0b still=%0b", flipped, still));
      end else begin
        want = pending.pop_front();
        if (flipped !== want.flipped)
          report_mismatch($sformatf("flipped=%0b, want %0b", flipped, want.flipped));
        if (still !== want.still)
          report_mismatch($sformatf("still=%0b, want %0b", still, want.still));
      end
    endtask
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic [1:0]       cfg_index_i = '0;
  logic [VAR_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  accel_t           accel_x_i   = '0;
  accel_t           accel_y_i   = '0;
  accel_t           accel_z_i   = '0;
  logic             out_stall_i = 1'b0;
  logic             cfg_ready_o;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             flipped_o;
  logic             still_o;

  bit               idle_on      = 1'b1;
  int               stall_left   = 0;
  int               stuck_cycles = 0;
  stillness_tracker tracker      = new();

  accel_stillness_detector u_top (.*);

  always #2 clk_i = ~clk_i;

  // result side: check each transaction, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_verdict(flipped_o, still_o);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  function automatic accel_t any_sample();
    return accel_t'($urandom_range(0, 65535));
  endfunction

  function automatic accel_t near_value(int c, int amp);
    int v;
    v = c + int'($urandom_range(0, 2 * amp)) - amp;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return accel_t'(v);
  endfunction

  task automatic send_sample(accel_t x, accel_t y, accel_t z);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= x;
    accel_y_i  <= y;
    accel_z_i  <= z;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_sample(x, y, z);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_put(cfg_reg_e idx, logic [VAR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, data);
  endtask

  task automatic write_regs(accel_t flip, logic [MOT_W-1:0] motion, logic [VAR_W-1:0] vlim);
    drain();
    cfg_put(CFG_FLIP, VAR_W'(flip));
    cfg_put(CFG_MOTION, VAR_W'(motion));
    cfg_put(CFG_VAR, vlim);
    cfg_valid_i <= 1'b0;
  endtask

  // x alternates +-10 (spread 2000), y has a negative sum that is not a multiple
  // of the window, z toggles across the default flip level
  task automatic directed_window();
    for (int i = 0; i < WINDOW_LENGTH; i++)
      send_sample((i % 2) ? -16'sd10 : 16'sd10, (i == 7) ? -16'sd8 : -16'sd7,
                  16'sd819 + accel_t'(i % 2));
  endtask

  // mostly noisy samples around a center so quiet windows form, plus jumps
  task automatic random_stretch(int count);
    int cx;
    int cy;
    int cz;
    int amp;
    int pick;
    cx  = int'(any_sample());
    cy  = int'(any_sample());
    cz  = int'(tracker.flip_level);
    amp = $urandom_range(0, 60);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        cx  = int'(any_sample());
        cy  = int'(any_sample());
        cz  = $urandom_range(0, 1) ? int'(tracker.flip_level) : int'(any_sample());
        amp = $urandom_range(0, 60);
      end
      if (pick >= 5 && pick < 8)
        send_sample(any_sample(), any_sample(), any_sample());
      else
        send_sample(near_value(cx, amp), near_value(cy, amp), near_value(cz, amp));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // spread exactly at the limit stays moving
    write_regs(16'sd819, 16'd100, 32'd100);
    directed_window();
    // one above: quiet, means x 0, y -8, z 819
    write_regs(16'sd819, 16'd100, 32'd101);
    directed_window();
    send_sample(16'sd100, -16'sd108, 16'sd919);
    send_sample(-16'sd100, -16'sd8, 16'sd820);
    send_sample(16'sd0, 16'sd93, 16'sd819);
    send_sample(16'sd32767, -16'sd32768, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768);

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != 3 && p != PHASES - 1);
      case (p)
        0: write_regs(-16'sd32768, 16'd0, 32'hFFFF_FFFF);
        1: write_regs(16'sd32767, 16'hFFFF, 32'd0);
        2: write_regs(16'sd819, 16'd164, 32'd3355);
        default: begin
          write_regs(any_sample(),
                     ($urandom_range(0, 3) == 0) ? MOT_W'($urandom_range(0, 65535))
                                                 : MOT_W'($urandom_range(0, 300)),
                     ($urandom_range(0, 3) == 0) ? VAR_W'($urandom)
                                                 : VAR_W'($urandom_range(0, 6000)));
        end
      endcase
      random_stretch(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.pending.size() != 0) tracker.report_mismatch("results still missing at end");
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/asd_pkg.sv
sv/asd_win_mem.sv
sv/asd_wcalc.sv
sv/accel_stillness_detector.sv
dv/tb_accel_stillness_detector.sv
